// ===== hw/rtl/iidl_pkg.sv =====
// shared types and constants of the indexed insert/delete list
package iidl_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int WORD_W     = 32;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 5;
	localparam int ACTION_W   = 3;
	localparam int S_DATA_W   = 40;
	localparam int M_DATA_W   = 40;

	typedef enum logic [ACTION_W-1:0] {
		ACT_APPEND    = 3'd0,
		ACT_INSERT    = 3'd1,
		ACT_OVERWRITE = 3'd2,
		ACT_REMOVE    = 3'd3,
		ACT_READ      = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_WRITE,
		OP_INSERT,
		OP_REMOVE
	} cell_op_t;

	typedef struct packed {
		cell_op_t               op;
		logic [CNT_W-1:0]       idx;
		logic [CNT_W-1:0]       count;
		logic [DATA_WIDTH-1:0]  value;
	} cell_cmd_t;

endpackage

// ===== hw/rtl/iidl_cell.sv =====
// one storage cell of the list row, shifting with its neighbors
module iidl_cell
	import iidl_pkg::*;
(
	input  logic                  clk,
	input  logic [CNT_W-1:0]      pos,
	input  cell_cmd_t             cmd,
	input  logic [DATA_WIDTH-1:0] lower,
	input  logic [DATA_WIDTH-1:0] upper,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] rd_data
);

	logic [DATA_WIDTH-1:0] entry_q;
	logic [DATA_WIDTH-1:0] entry_d;
	logic [CNT_W-1:0]      pos_next;

	assign pos_next = pos + CNT_W'(1);

	always_comb begin
		entry_d = entry_q;
		case (cmd.op)
			OP_WRITE: begin
				if (pos == cmd.idx) entry_d = cmd.value;
			end
			OP_INSERT: begin
				if (pos == cmd.idx) entry_d = cmd.value;
				else if (pos > cmd.idx && pos <= cmd.count) entry_d = lower;
			end
			OP_REMOVE: begin
				if (pos >= cmd.idx && pos_next < cmd.count) entry_d = upper;
				else if (pos_next == cmd.count) entry_d = '0;
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	assign data    = entry_q;
	// read tap: zero unless this cell is addressed, so the row can be or-ed
	assign rd_data = (pos == cmd.idx) ? entry_q : '0;

endmodule

// ===== hw/rtl/indexed_insert_delete_list.sv =====
// Indexed insert/delete list: an ordered list of up to CAPACITY signed words held in a row of
// cells, one word per cell, with a fill count. Each request beat (append, insert, overwrite,
// remove or read) completes in the clock in which it is accepted: every cell loads, keeps or
// takes its neighbor's word in parallel, so an insert or remove shifts the whole tail in the
// same clock. One result beat per request appears in the next cycle from an output register;
// the block takes one request per cycle as long as the result side keeps taking beats. Any
// action but append rejects an index at or beyond the count with no change; a read then returns 0.
module indexed_insert_delete_list
	import iidl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // index[3:0], value[35:4], zero fill
	input  logic [ACTION_W-1:0] s_tuser,  // action[2:0]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata   // read_data[31:0], status[33:32], item_count[38:34], zero fill
);

	logic                  accept;
	logic [IDX_W-1:0]      in_index;
	logic [WORD_W-1:0]     in_value;
	logic [CNT_W-1:0]      idx_ext;
	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      fill_d;
	logic                  in_range;
	logic                  full;
	cell_cmd_t             cmd;
	status_t               status_d;
	logic                  read_hit;
	logic [DATA_WIDTH-1:0] row_rd;
	logic [WORD_W-1:0]     read_word;

	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

	logic                  out_valid_q;
	logic [WORD_W-1:0]     out_read_q;
	status_t               out_status_q;
	logic [COUNT_W-1:0]    out_count_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign in_index = s_tdata[IDX_W-1:0];
	assign in_value = s_tdata[IDX_W +: WORD_W];
	assign idx_ext  = CNT_W'(in_index);
	assign in_range = idx_ext < fill_q;
	assign full     = fill_q >= CNT_W'(CAPACITY);

	always_comb begin
		cmd.op    = OP_NONE;
		cmd.idx   = idx_ext;
		cmd.count = fill_q;
		cmd.value = in_value[DATA_WIDTH-1:0];
		fill_d    = fill_q;
		status_d  = ST_DONE;
		read_hit  = 1'b0;
		case (action_t'(s_tuser))
			ACT_APPEND: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.op  = OP_WRITE;
					cmd.idx = fill_q;
					fill_d  = fill_q + CNT_W'(1);
				end
			end
			ACT_INSERT: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					cmd.op = OP_INSERT;
					fill_d = fill_q + CNT_W'(1);
				end
			end
			ACT_OVERWRITE: begin
				if (!in_range) status_d = ST_RANGE;
				else cmd.op = OP_WRITE;
			end
			ACT_REMOVE: begin
				if (!in_range) begin
					status_d = ST_RANGE;
				end else begin
					cmd.op = OP_REMOVE;
					fill_d = fill_q - CNT_W'(1);
				end
			end
			ACT_READ: begin
				if (!in_range) status_d = ST_RANGE;
				else read_hit = 1'b1;
			end
			default: begin
				status_d = ST_DONE;
			end
		endcase
		if (!accept) cmd.op = OP_NONE;
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] lower;
		logic [DATA_WIDTH-1:0] upper;
		if (g == 0) begin : g_first
			assign lower = '0;
		end else begin : g_lower
			assign lower = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign upper = '0;
		end else begin : g_upper
			assign upper = cell_data[g+1];
		end
		iidl_cell u_cell (
			.clk     (clk),
			.pos     (CNT_W'(g)),
			.cmd     (cmd),
			.lower   (lower),
			.upper   (upper),
			.data    (cell_data[g]),
			.rd_data (cell_rd[g])
		);
	end

	always_comb begin
		row_rd = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			row_rd = row_rd | cell_rd[i];
		end
	end

	assign read_word = read_hit ? WORD_W'($signed(row_rd)) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) fill_q <= fill_d;
			if (accept) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_read_q   <= read_word;
			out_status_q <= status_d;
			out_count_q  <= COUNT_W'(fill_d);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_DATA_W'({out_count_q, out_status_q, out_read_q});

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_count_q == COUNT_W'(fill_q))
		else $error("reported count differs from fill count");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_DONE |-> out_read_q == '0)
		else $error("rejected request returned data");

	a_reject_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status_d != ST_DONE |=> $stable(fill_q))
		else $error("rejected request changed the count");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the indexed insert/delete list: queued requests against a shadow list
module testbench;
	import iidl_pkg::*;

	localparam int CLK_HALF    = 2;
	localparam int RAND_REQS   = 600;
	localparam int QUIET_TAIL  = 80;
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 60;
	localparam int MAX_REPORTS = 10;
	localparam int ST_LSB      = WORD_W;
	localparam int CNT_LSB     = WORD_W + STATUS_W;
	localparam int FILL_W      = S_DATA_W - WORD_W - IDX_W;

	localparam logic [ACTION_W-1:0] ACT_UNUSED_TOP = '1;
	localparam logic [IDX_W-1:0]    IDX_TOP        = '1;

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [IDX_W-1:0]    index;
		logic [WORD_W-1:0]   value;
		bit                  drain_first;
	} list_req_t;

	typedef struct {
		logic [WORD_W-1:0]  read_data;
		status_t            status;
		logic [COUNT_W-1:0] item_count;
	} list_rsp_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata  = '0; // index[3:0], value[35:4], zero fill
	logic [ACTION_W-1:0] s_tuser  = '0; // action[2:0]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata; // read_data[31:0], status[33:32], item_count[38:34], zero fill

	list_req_t pending_reqs[$];
	list_rsp_t awaited_rsps[$];
	list_req_t req_on_bus;
	list_rsp_t fresh_rsp;
	list_rsp_t want;

	logic [DATA_WIDTH-1:0] shadow_words[CAPACITY];
	int                    shadow_len = 0;
	int                    plan_len   = 0;

	int mismatches  = 0;
	int send_gap    = 0;
	int take_gap    = 0;
	int taken_reqs  = 0;
	int hold_left   = 0;
	bit hold_done   = 1'b0;

	indexed_insert_delete_list dut (
		.clk,
		.arst_n,
		.s_tvalid,
		.s_tready,
		.s_tdata,
		.s_tuser,
		.m_tvalid,
		.m_tready,
		.m_tdata
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	task automatic predict_list_op(input list_req_t req, output list_rsp_t rsp);
		int i;
		rsp.read_data = '0;
		rsp.status    = ST_DONE;
		case (req.action)
			ACT_APPEND: begin
				if (shadow_len >= CAPACITY) begin
					rsp.status = ST_FULL;
				end else begin
					shadow_words[shadow_len] = req.value[DATA_WIDTH-1:0];
					shadow_len++;
				end
			end
			ACT_INSERT: begin
				if (req.index >= shadow_len) begin
					rsp.status = ST_RANGE;
				end else if (shadow_len >= CAPACITY) begin
					rsp.status = ST_FULL;
				end else begin
					for (i = shadow_len; i > req.index; i--)
						shadow_words[i] = shadow_words[i-1];
					shadow_words[req.index] = req.value[DATA_WIDTH-1:0];
					shadow_len++;
				end
			end
			ACT_OVERWRITE: begin
				if (req.index >= shadow_len)
					rsp.status = ST_RANGE;
				else
					shadow_words[req.index] = req.value[DATA_WIDTH-1:0];
			end
			ACT_REMOVE: begin
				if (req.index >= shadow_len) begin
					rsp.status = ST_RANGE;
				end else begin
					for (i = req.index; i + 1 < shadow_len; i++)
						shadow_words[i] = shadow_words[i+1];
					shadow_words[shadow_len-1] = '0;
					shadow_len--;
				end
			end
			ACT_READ: begin
				if (req.index >= shadow_len)
					rsp.status = ST_RANGE;
				else
					rsp.read_data = WORD_W'($signed(shadow_words[req.index]));
			end
			default: begin
			end
		endcase
		rsp.item_count = shadow_len[COUNT_W-1:0];
	endtask

	// keeps a rough count of entries so that random indexes mostly land in range
	task automatic queue_req(input logic [ACTION_W-1:0] action, input logic [IDX_W-1:0] index,
			input logic [WORD_W-1:0] value, input bit drain_first);
		list_req_t req;
		req.action      = action;
		req.index       = index;
		req.value       = value;
		req.drain_first = drain_first;
		pending_reqs = {pending_reqs, req};
		case (action)
			ACT_APPEND: begin
				if (plan_len < CAPACITY)
					plan_len++;
			end
			ACT_INSERT: begin
				if (index < plan_len && plan_len < CAPACITY)
					plan_len++;
			end
			ACT_REMOVE: begin
				if (index < plan_len)
					plan_len--;
			end
			default: begin
			end
		endcase
	endtask

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0: return {1'b1, {(WORD_W-1){1'b0}}};
			1: return {1'b0, {(WORD_W-1){1'b1}}};
			2: return '1;
			3: return '0;
			default: return $urandom();
		endcase
	endfunction

	initial begin : stimulus
		int                  target_len;
		int                  roll;
		logic [ACTION_W-1:0] act;
		logic [IDX_W-1:0]    idx;
		logic [WORD_W-1:0]   word;

		target_len = 0;

		// empty list: every indexed request is out of range, insert at the count too
		queue_req(ACT_READ, '0, pick_word(), 1'b0);
		queue_req(ACT_REMOVE, '0, pick_word(), 1'b0);
		queue_req(ACT_OVERWRITE, '0, pick_word(), 1'b0);
		queue_req(ACT_INSERT, '0, pick_word(), 1'b0);

		for (int k = 0; k < CAPACITY; k++) begin
			case (k)
				0: word = {1'b1, {(WORD_W-1){1'b0}}};
				1: word = {1'b0, {(WORD_W-1){1'b1}}};
				2: word = '1;
				3: word = '0;
				default: word = $urandom();
			endcase
			queue_req(ACT_APPEND, IDX_TOP, word, 1'b0);
		end

		// full list
		queue_req(ACT_APPEND, '0, pick_word(), 1'b0);
		queue_req(ACT_INSERT, IDX_W'(3), pick_word(), 1'b0);
		queue_req(ACT_READ, IDX_TOP, '0, 1'b0);
		queue_req(ACT_REMOVE, '0, '0, 1'b0);
		queue_req(ACT_INSERT, IDX_TOP, pick_word(), 1'b0);
		queue_req(ACT_UNUSED_TOP, IDX_TOP, '1, 1'b0);

		for (int n = 0; n < RAND_REQS; n++) begin
			if (n % 40 == 0)
				target_len = $urandom_range(0, CAPACITY);
			roll = $urandom_range(0, 99);
			if (roll < 4)
				act = ACTION_W'($urandom_range(ACT_READ + 1, ACT_UNUSED_TOP));
			else if (roll < (plan_len < target_len ? 55 : 20))
				act = ($urandom_range(0, 2) == 0) ? ACT_INSERT : ACT_APPEND;
			else if (roll < (plan_len < target_len ? 70 : 60))
				act = ACT_REMOVE;
			else
				act = ($urandom_range(0, 1) == 0) ? ACT_OVERWRITE : ACT_READ;
			if (plan_len != 0 && $urandom_range(0, 7) != 0)
				idx = IDX_W'($urandom_range(0, plan_len - 1));
			else
				idx = IDX_W'($urandom_range(0, IDX_TOP));
			queue_req(act, idx, pick_word(), n == 0 || n == RAND_REQS / 2);
		end

		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || awaited_rsps.size() != 0);
		repeat (8) @(posedge clk);

		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_list_op(req_on_bus, fresh_rsp);
				awaited_rsps = {awaited_rsps, fresh_rsp};
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_reqs.size() == 0
						|| (pending_reqs[0].drain_first && awaited_rsps.size() != 0)) begin
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
					s_tvalid <= 1'b0;
					send_gap <= $urandom_range(0, 5);
				end else begin
					req_on_bus = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {{FILL_W{1'b0}}, req_on_bus.value, req_on_bus.index};
					s_tuser  <= req_on_bus.action;
				end
			end
		end
	end

	// one long result stall after a fixed number of accepted requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_reqs <= 0;
			hold_left  <= 0;
			hold_done  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				taken_reqs <= taken_reqs + 1;
			if (!hold_done && taken_reqs == HOLD_AT) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			take_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result beat %h", m_tdata);
				end else begin
					want = awaited_rsps.pop_front();
					if (m_tdata[WORD_W-1:0] !== want.read_data
							|| m_tdata[ST_LSB +: STATUS_W] !== want.status
							|| m_tdata[CNT_LSB +: COUNT_W] !== want.item_count) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: expected %h %0d %0d, got %h %0d %0d",
								want.read_data, want.status, want.item_count,
								m_tdata[WORD_W-1:0], m_tdata[ST_LSB +: STATUS_W],
								m_tdata[CNT_LSB +: COUNT_W]);
					end
				end
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (take_gap != 0) begin
				m_tready <= 1'b0;
				take_gap <= take_gap - 1;
			end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				take_gap <= $urandom_range(0, 5);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

endmodule

// ===== sim.f =====
hw/rtl/iidl_pkg.sv
hw/rtl/iidl_cell.sv
hw/rtl/indexed_insert_delete_list.sv
verif/testbench.sv
